@@ hw/rtl/vic_pkg.sv @@
package vic_pkg;

   localparam int POS_W = 6;
   localparam int COLOR_W = 32;
   localparam int GRID_BITS_DEF = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   localparam logic [2:0] REG_CULL_ENABLE = 3'd0;
   localparam logic [2:0] REG_BORDER_OPAQUE = 3'd1;
   localparam logic [2:0] REG_BOUND_MIN_X = 3'd2;
   localparam logic [2:0] REG_BOUND_MAX_X = 3'd3;
   localparam logic [2:0] REG_BOUND_MIN_Y = 3'd4;
   localparam logic [2:0] REG_BOUND_MIN_Z = 3'd5;
   localparam logic [2:0] REG_BOUND_MAX_Z = 3'd6;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [POS_W-1:0] BOUND_MIN_RST = 6'd0;
   localparam logic [POS_W-1:0] BOUND_MAX_RST = 6'd63;

   typedef struct packed {
      logic cull_enable;
      logic border_opaque;
      logic [POS_W-1:0] min_x;
      logic [POS_W-1:0] max_x;
      logic [POS_W-1:0] min_y;
      logic [POS_W-1:0] min_z;
      logic [POS_W-1:0] max_z;
   } cfg_type;

   typedef struct packed {
      logic cmd;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] pos_z;
      logic [COLOR_W-1:0] color;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WR,
      ST_QUERY
   } back_state_type;

endpackage

@@ hw/rtl/vic_ram.sv @@
module vic_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/vic_front.sv @@
module vic_front #(
   parameter int GRID_BITS = vic_pkg::GRID_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             hold,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_command,
   input  logic [vic_pkg::POS_W-1:0]        req_pos_x,
   input  logic [vic_pkg::POS_W-1:0]        req_pos_y,
   input  logic [vic_pkg::POS_W-1:0]        req_pos_z,
   input  logic [vic_pkg::COLOR_W-1:0]      req_voxel_color,
   output logic                             push_valid,
   input  logic                             push_ready,
   output vic_pkg::entry_type               push_data
);

   import vic_pkg::*;

   logic      stage_valid_ff, stage_valid_in;
   entry_type stage_ff, stage_in;
   logic      accept;
   logic      keep;

   function automatic logic pos_in_grid(input logic [POS_W-1:0] p);
      return int'(p) < (1 << GRID_BITS);
   endfunction

   assign req_ready = !hold && (!stage_valid_ff || push_ready);
   assign accept = req_valid && req_ready;

   // An insert outside the grid changes nothing and yields no result, so it is
   // dropped here and never reaches the back end.
   always_comb begin
      keep = (req_command == CMD_QUERY) ||
             (pos_in_grid(req_pos_x) && pos_in_grid(req_pos_y) && pos_in_grid(req_pos_z));
      stage_in = stage_ff;
      stage_valid_in = stage_valid_ff && !push_ready;
      if (accept) begin
         stage_valid_in = keep;
         stage_in.cmd = req_command;
         stage_in.pos_x = req_pos_x;
         stage_in.pos_y = req_pos_y;
         stage_in.pos_z = req_pos_z;
         stage_in.color = req_voxel_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_ff <= stage_in;
   end

   assign push_valid = stage_valid_ff;
   assign push_data = stage_ff;

endmodule

@@ hw/rtl/vic_queue.sv @@
module vic_queue #(
   parameter int DEPTH = vic_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  vic_pkg::entry_type push_data,
   output logic               pop_valid,
   input  logic               pop,
   output vic_pkg::entry_type pop_data
);

   import vic_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   entry_type        slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      case ({do_push, do_pop})
         2'b10: count_in = count_ff + CNT_W'(1);
         2'b01: count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/vic_back.sv @@
module vic_back #(
   parameter int GRID_BITS = vic_pkg::GRID_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  vic_pkg::cfg_type            cfg,
   input  logic                        q_valid,
   output logic                        q_pop,
   input  vic_pkg::entry_type          q_data,
   output logic                        clearing,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_visible,
   output logic [vic_pkg::POS_W-1:0]   rsp_out_x,
   output logic [vic_pkg::POS_W-1:0]   rsp_out_y,
   output logic [vic_pkg::POS_W-1:0]   rsp_out_z,
   output logic [vic_pkg::COLOR_W-1:0] rsp_out_color
);

   import vic_pkg::*;

   localparam int G = GRID_BITS;
   localparam int SIDE = 1 << G;
   localparam int ROW_AW = 2 * G;
   localparam int ROWS = 1 << ROW_AW;
   localparam int CW = ((G > POS_W) ? G : POS_W) + 2;
   localparam logic signed [CW-1:0] ONE_S = CW'(1);
   localparam logic signed [CW-1:0] SIDE_S = CW'(SIDE);
   localparam logic [SIDE-1:0] BIT0 = SIDE'(1);

   // Query sequence: one occupancy row per step, the row of the voxel itself
   // first (it holds both z neighbors), then the four x and y neighbor rows.
   localparam logic [2:0] STEP_ROW_Z = 3'd0;
   localparam logic [2:0] STEP_XM = 3'd1;
   localparam logic [2:0] STEP_XP = 3'd2;
   localparam logic [2:0] STEP_YM = 3'd3;
   localparam logic [2:0] STEP_YP = 3'd4;
   localparam logic [2:0] STEP_DONE = 3'd5;

   back_state_type state_ff, state_in;
   entry_type      cur_ff, cur_in;
   logic [2:0]     step_ff, step_in;
   logic           vis_ff, vis_in;
   logic [ROW_AW-1:0] clr_ff, clr_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_vis_ff, rsp_vis_in;
   logic [POS_W-1:0] rsp_x_ff, rsp_x_in;
   logic [POS_W-1:0] rsp_y_ff, rsp_y_in;
   logic [POS_W-1:0] rsp_z_ff, rsp_z_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;

   logic              ram_en;
   logic              ram_we;
   logic [ROW_AW-1:0] ram_addr;
   logic [SIDE-1:0]   ram_wdata;
   logic [SIDE-1:0]   ram_rdata;

   logic signed [CW-1:0] xs, ys, zs;
   logic signed [CW-1:0] iss_x, iss_y;
   logic [ROW_AW-1:0]    row_addr;
   logic [2:0]           ev_k;
   logic signed [CW-1:0] ev_x, ev_y, ev_za, ev_zb;
   logic                 exposed;
   logic                 out_free;

   function automatic logic signed [CW-1:0] ext(input logic [POS_W-1:0] p);
      return signed'({{(CW - POS_W){1'b0}}, p});
   endfunction

   function automatic logic signed [CW-1:0] row_dx(input logic [2:0] k);
      logic signed [CW-1:0] d;
      unique case (k)
         STEP_XM: d = '1;
         STEP_XP: d = ONE_S;
         default: d = '0;
      endcase
      return d;
   endfunction

   function automatic logic signed [CW-1:0] row_dy(input logic [2:0] k);
      logic signed [CW-1:0] d;
      unique case (k)
         STEP_YM: d = '1;
         STEP_YP: d = ONE_S;
         default: d = '0;
      endcase
      return d;
   endfunction

   function automatic logic in_grid(input logic signed [CW-1:0] n);
      return !n[CW-1] && (n < SIDE_S);
   endfunction

   // A face is open when its neighbor is neither set in the row nor border
   // that the configuration makes opaque.
   function automatic logic face_open(input logic signed [CW-1:0] nx,
                                      input logic signed [CW-1:0] ny,
                                      input logic signed [CW-1:0] nz,
                                      input logic [SIDE-1:0] row,
                                      input cfg_type c);
      logic beyond;
      logic occ;
      beyond = (nx > ext(c.max_x)) || (nx < ext(c.min_x)) ||
               (nz > ext(c.max_z)) || (nz < ext(c.min_z)) ||
               (ny < ext(c.min_y));
      occ = in_grid(nx) && in_grid(ny) && in_grid(nz) && row[nz[G-1:0]];
      return !((c.border_opaque && beyond) || occ);
   endfunction

   vic_ram #(
      .WIDTH(SIDE),
      .DEPTH(ROWS)
   ) u_occ_ram (
      .clock(clock),
      .en   (ram_en),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   assign xs = ext(cur_ff.pos_x);
   assign ys = ext(cur_ff.pos_y);
   assign zs = ext(cur_ff.pos_z);
   assign iss_x = xs + row_dx(step_ff);
   assign iss_y = ys + row_dy(step_ff);
   assign row_addr = {iss_x[G-1:0], iss_y[G-1:0]};

   // The row read in the previous step is evaluated now.
   assign ev_k = step_ff - 3'd1;
   assign ev_x = xs + row_dx(ev_k);
   assign ev_y = ys + row_dy(ev_k);
   assign ev_za = (ev_k == STEP_ROW_Z) ? zs - ONE_S : zs;
   assign ev_zb = (ev_k == STEP_ROW_Z) ? zs + ONE_S : zs;
   assign exposed = face_open(ev_x, ev_y, ev_za, ram_rdata, cfg) ||
                    face_open(ev_x, ev_y, ev_zb, ram_rdata, cfg);

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      step_in = step_ff;
      vis_in = vis_ff;
      clr_in = clr_ff;
      q_pop = 1'b0;
      ram_en = 1'b0;
      ram_we = 1'b0;
      ram_addr = row_addr;
      ram_wdata = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_vis_in = rsp_vis_ff;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      rsp_z_in = rsp_z_ff;
      rsp_color_in = rsp_color_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_en = 1'b1;
            ram_we = 1'b1;
            ram_addr = clr_ff;
            clr_in = clr_ff + ROW_AW'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               cur_in = q_data;
               step_in = STEP_ROW_Z;
               vis_in = 1'b0;
               state_in = (q_data.cmd == CMD_QUERY) ? ST_QUERY : ST_INS_RD;
            end
         end
         ST_INS_RD: begin
            ram_en = 1'b1;
            state_in = ST_INS_WR;
         end
         ST_INS_WR: begin
            ram_en = 1'b1;
            ram_we = 1'b1;
            ram_wdata = ram_rdata | (BIT0 << zs[G-1:0]);
            state_in = ST_IDLE;
         end
         ST_QUERY: begin
            if (step_ff != STEP_DONE) begin
               ram_en = 1'b1;
               step_in = step_ff + 3'd1;
               if (step_ff != STEP_ROW_Z) begin
                  vis_in = vis_ff || exposed;
               end
            end else if (out_free) begin
               // The last row stays in the read register, so waiting here for
               // the output slot gives the same answer on every cycle.
               rsp_valid_in = 1'b1;
               rsp_vis_in = !cfg.cull_enable || vis_ff || exposed;
               rsp_x_in = cur_ff.pos_x;
               rsp_y_in = cur_ff.pos_y;
               rsp_z_in = cur_ff.pos_z;
               rsp_color_in = cur_ff.color;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      step_ff <= step_in;
      vis_ff <= vis_in;
      rsp_vis_ff <= rsp_vis_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_z_ff <= rsp_z_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign clearing = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_visible = rsp_vis_ff;
   assign rsp_out_x = rsp_x_ff;
   assign rsp_out_y = rsp_y_ff;
   assign rsp_out_z = rsp_z_ff;
   assign rsp_out_color = rsp_color_ff;

`ifndef SYNTH
   a_no_write_in_query: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_QUERY) |-> !ram_we)
      else $error("occupancy written during a query");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE) && q_valid)
      else $error("queue popped outside idle");

   a_clear_runs_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) && !(&clr_ff) |=> (state_ff == ST_CLEAR))
      else $error("clearing pass ended early");

   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past((state_ff == ST_QUERY) && (step_ff == STEP_DONE)))
      else $error("result raised outside a finished query");

   a_insert_writes_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_RD) |=> ram_we && (state_ff == ST_INS_WR))
      else $error("insert read not followed by its write");
`endif

endmodule

@@ hw/rtl/voxel_interior_cull_top.sv @@
// Six-neighbor interior voxel culling over a 2^GRID_BITS cube of one-bit
// occupancy, kept in a single-port RAM as one row per (x, y) holding all z
// cells. After reset the block sweeps that RAM to zero, one row per cycle,
// and holds req_ready low until the sweep is done; register writes are taken
// during the sweep. An insert item (command 0) runs through dequeue, row read
// and row write; an insert outside the grid is dropped on entry. A query item
// (command 1) runs through dequeue, five row reads on the single RAM port
// (own row for both z faces, then x-1, x+1, y-1, y+1), and the final decision,
// and yields one result carrying the visible flag with the coordinates and
// color unchanged. A two-item queue separates the input stage from the back
// end, and the result sits in an output register, so new items are accepted
// while a result waits. Registers at byte addresses 4*i: cull_enable,
// border_opaque, bound_min_x, bound_max_x, bound_min_y, bound_min_z,
// bound_max_z; write them only while the block is idle.
module voxel_interior_cull_top #(
   parameter int GRID_BITS = vic_pkg::GRID_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_command,
   input  logic [vic_pkg::POS_W-1:0]   req_pos_x,
   input  logic [vic_pkg::POS_W-1:0]   req_pos_y,
   input  logic [vic_pkg::POS_W-1:0]   req_pos_z,
   input  logic [vic_pkg::COLOR_W-1:0] req_voxel_color,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_visible,
   output logic [vic_pkg::POS_W-1:0]   rsp_out_x,
   output logic [vic_pkg::POS_W-1:0]   rsp_out_y,
   output logic [vic_pkg::POS_W-1:0]   rsp_out_z,
   output logic [vic_pkg::COLOR_W-1:0] rsp_out_color,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [vic_pkg::CSR_AW-1:0]  paddr,
   input  logic [vic_pkg::CSR_DW-1:0]  pwdata,
   output logic [vic_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);

   import vic_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       csr_write;
   logic [2:0] csr_index;
   logic       clearing;
   logic       push_valid;
   logic       push_ready;
   entry_type  push_data;
   logic       q_valid;
   logic       q_pop;
   entry_type  q_data;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_CULL_ENABLE: cfg_in.cull_enable = pwdata[0];
            REG_BORDER_OPAQUE: cfg_in.border_opaque = pwdata[0];
            REG_BOUND_MIN_X: cfg_in.min_x = pwdata[POS_W-1:0];
            REG_BOUND_MAX_X: cfg_in.max_x = pwdata[POS_W-1:0];
            REG_BOUND_MIN_Y: cfg_in.min_y = pwdata[POS_W-1:0];
            REG_BOUND_MIN_Z: cfg_in.min_z = pwdata[POS_W-1:0];
            REG_BOUND_MAX_Z: cfg_in.max_z = pwdata[POS_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CULL_ENABLE: prdata = CSR_DW'(cfg_ff.cull_enable);
         REG_BORDER_OPAQUE: prdata = CSR_DW'(cfg_ff.border_opaque);
         REG_BOUND_MIN_X: prdata = CSR_DW'(cfg_ff.min_x);
         REG_BOUND_MAX_X: prdata = CSR_DW'(cfg_ff.max_x);
         REG_BOUND_MIN_Y: prdata = CSR_DW'(cfg_ff.min_y);
         REG_BOUND_MIN_Z: prdata = CSR_DW'(cfg_ff.min_z);
         REG_BOUND_MAX_Z: prdata = CSR_DW'(cfg_ff.max_z);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cull_enable <= 1'b1;
         cfg_ff.border_opaque <= 1'b0;
         cfg_ff.min_x <= BOUND_MIN_RST;
         cfg_ff.max_x <= BOUND_MAX_RST;
         cfg_ff.min_y <= BOUND_MIN_RST;
         cfg_ff.min_z <= BOUND_MIN_RST;
         cfg_ff.max_z <= BOUND_MAX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vic_front #(
      .GRID_BITS(GRID_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .hold           (clearing),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_voxel_color(req_voxel_color),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   vic_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .pop_valid (q_valid),
      .pop       (q_pop),
      .pop_data  (q_data)
   );

   vic_back #(
      .GRID_BITS(GRID_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_data       (q_data),
      .clearing     (clearing),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_visible  (rsp_visible),
      .rsp_out_x    (rsp_out_x),
      .rsp_out_y    (rsp_out_y),
      .rsp_out_z    (rsp_out_z),
      .rsp_out_color(rsp_out_color)
   );

endmodule
